### hw/rtl/iir_df2t_pkg.sv
// Shared types and constants for the third-order DF2T IIR filter.
// No dependencies; imported by the coefficient interface and all filter modules.
package iir_df2t_pkg;

    localparam int COEF_BITS    = 18;
    localparam int DELAY_BITS   = 40;
    localparam int CFG_IDX_BITS = 3;
    localparam int NUM_COEFS    = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COEF_3 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_1 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_2 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEN_COEF_3 = 3'd6;

    // 1.0 in Q3.14
    localparam logic signed [COEF_BITS-1:0] NUM_COEF_0_RESET = 18'sd16384;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_UPD
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic upd_en;
    } t_cell_ctl;

endpackage

### hw/rtl/iir_df2t_if.sv
// Valid/ready channel interfaces for the DF2T IIR filter: sample in, result out
// and coefficient writes. Depends on iir_df2t_pkg.
interface iir_df2t_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df2t_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iir_df2t_cfg_if import iir_df2t_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [CFG_IDX_BITS-1:0]     index;
    logic signed [COEF_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/iir_df2t_head.sv
// Output stage: b0*x + first delay term, round half up, saturate to a sample.
// Depends on iir_df2t_pkg.
module iir_df2t_head import iir_df2t_pkg::*; #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    input  logic signed [DELAY_BITS-1:0]  i_delay,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_clip
);

    localparam int PW = COEF_BITS + SAMPLE_BITS;
    localparam int AW = ((PW > DELAY_BITS) ? PW : DELAY_BITS) + 1;

    logic signed [PW-1:0]          w_prod;
    logic signed [AW-1:0]          w_acc;
    logic signed [AW:0]            w_rnd;
    logic signed [AW:0]            w_shift;
    logic                          w_ovf;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_clip;

    always_comb begin
        w_prod  = i_coef * i_x;
        w_acc   = AW'(w_prod) + AW'(i_delay);
        w_rnd   = (AW+1)'(w_acc)
                + $signed({{(AW+1-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}});
        w_shift = w_rnd >>> COEF_FRAC_BITS;
        w_ovf   = !((&w_shift[AW:SAMPLE_BITS-1]) || !(|w_shift[AW:SAMPLE_BITS-1]));
        if (w_ovf) begin
            w_y = w_shift[AW] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            w_y = w_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_y    <= w_y;
            r_clip <= w_ovf;
        end
    end

    assign o_y    = r_y;
    assign o_clip = r_clip;

endmodule

### hw/rtl/iir_df2t_cell.sv
// One delay cell of the transposed chain: holds one 40-bit delay term and
// takes its neighbor's term each update. Depends on iir_df2t_pkg.
module iir_df2t_cell import iir_df2t_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic signed [COEF_BITS-1:0]   i_num_coef,
    input  logic signed [COEF_BITS-1:0]   i_den_coef,
    input  logic signed [DELAY_BITS-1:0]  i_next,
    output logic signed [DELAY_BITS-1:0]  o_delay,
    output logic                          o_sat
);

    localparam int PW = COEF_BITS + SAMPLE_BITS;
    localparam int VW = ((PW > DELAY_BITS) ? PW : DELAY_BITS) + 2;

    logic signed [PW-1:0]         r_nx;
    logic signed [PW-1:0]         w_dy;
    logic signed [VW-1:0]         w_sum;
    logic                         w_ovf;
    logic signed [DELAY_BITS-1:0] n_delay;
    logic signed [DELAY_BITS-1:0] r_delay;

    always_comb begin
        w_dy  = i_den_coef * i_y;
        w_sum = VW'(i_next) + VW'(r_nx) - VW'(w_dy);
        w_ovf = !((&w_sum[VW-1:DELAY_BITS-1]) || !(|w_sum[VW-1:DELAY_BITS-1]));
        if (w_ovf) begin
            n_delay = w_sum[VW-1] ? {1'b1, {(DELAY_BITS-1){1'b0}}}
                                  : {1'b0, {(DELAY_BITS-1){1'b1}}};
        end else begin
            n_delay = w_sum[DELAY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_nx <= i_num_coef * i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
        end else if (i_ctl.upd_en) begin
            r_delay <= n_delay;
        end
    end

    assign o_delay = r_delay;
    assign o_sat   = w_ovf;

endmodule

### hw/rtl/iir_df2t_filter.sv
// Top level of the DF2T IIR filter: coefficient registers, sequencer, head stage,
// cell chain and result register. Depends on iir_df2t_pkg, the interfaces,
// iir_df2t_head and iir_df2t_cell.
//
// Each sample passes through S_CALC and then S_UPD. In S_CALC the head forms the
// rounded, saturated output from b0*x and the first delay term while every cell
// registers its b_j*x product; in S_UPD every cell adds its neighbor's
// term and subtracts a_j*y, and the result is loaded into the output
// register. A new sample is taken in S_UPD once the output register is free,
// and a result that is not taken holds the filter in S_UPD. The feedback of
// the output sample into the a_j*y products of the cells keeps a new sample
// from starting before the last one's update. The user must write coefficients
// only while the filter is idle; the block itself does not enforce this.
module iir_filter_df2t import iir_df2t_pkg::*; #(
    parameter int ORDER          = 3,
    parameter int COEF_FRAC_BITS = 14,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iir_df2t_in_if.sink    i_sample,
    iir_df2t_out_if.source o_result,
    iir_df2t_cfg_if.sink   i_cfg
);

    t_state                        r_state;
    t_state                        n_state;
    t_cell_ctl                     w_ctl;
    logic                          w_in_ready;
    logic                          w_accept;
    logic                          w_load_out;
    logic                          w_out_free;
    logic signed [COEF_BITS-1:0]   r_coef [0:NUM_COEFS-1];
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic                          w_y_clip;
    logic signed [DELAY_BITS-1:0]  w_delay [0:ORDER];
    logic [ORDER-1:0]              w_cell_sat;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_clipped;

    // coefficient registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= NUM_COEF_0_RESET;
            for (int k = 1; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_NUM_COEF_0, REG_NUM_COEF_1, REG_NUM_COEF_2, REG_NUM_COEF_3,
                REG_DEN_COEF_1, REG_DEN_COEF_2, REG_DEN_COEF_3: begin
                    r_coef[i_cfg.index] <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer
    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_sample.valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                w_ctl.mul_en = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    w_ctl.upd_en = 1'b1;
                    w_load_out   = 1'b1;
                    w_in_ready   = 1'b1;
                    n_state      = i_sample.valid ? S_CALC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept       = i_sample.valid && w_in_ready;
    assign i_sample.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample.sample_in;
        end
    end

    // datapath
    iir_df2t_head #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_head (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_x     (r_x),
        .i_coef  (r_coef[REG_NUM_COEF_0]),
        .i_delay (w_delay[0]),
        .o_y     (w_y),
        .o_clip  (w_y_clip)
    );

    assign w_delay[ORDER] = '0;

    for (genvar j = 1; j <= ORDER; j++) begin : g_cell
        iir_df2t_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_x        (r_x),
            .i_y        (w_y),
            .i_num_coef (r_coef[j]),
            .i_den_coef (r_coef[j + 3]),
            .i_next     (w_delay[j]),
            .o_delay    (w_delay[j-1]),
            .o_sat      (w_cell_sat[j-1])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_sample_out <= w_y;
            r_clipped    <= w_y_clip || (|w_cell_sat);
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.sample_out = r_sample_out;
    assign o_result.clipped    = r_clipped;

`ifndef ASSERT_OFF
    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |-> (r_state == S_IDLE || r_state == S_UPD))
        else $error("item accepted while filter busy");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (r_state == S_CALC))
        else $error("accepted item not processed");

    a_calc_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |=> (r_state == S_UPD))
        else $error("calc cycle not followed by update");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_UPD))
        else $error("result raised outside update cycle");
`endif

endmodule
